### hw/rtl/lfsc_pkg.sv
// Shared types, register map, direction codes and reset values for the line follower
// steering controller. No dependencies; lfsc_front, lfsc_back and the top level import it.

package lfsc_pkg;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_BASE_SPEED       = 3'd0,
        REG_PIVOT_SPEED      = 3'd1,
        REG_INNER_TURN_SPEED = 3'd2,
        REG_BOOST_GAIN       = 3'd3,
        REG_BOOST_LIMIT      = 3'd4,
        REG_RECENTER_COUNT   = 3'd5
    } lfsc_reg_t;

    localparam logic [7:0]        BASE_SPEED_RST       = 8'd88;
    localparam logic [7:0]        PIVOT_SPEED_RST      = 8'd110;
    localparam logic [7:0]        INNER_TURN_SPEED_RST = 8'd70;
    localparam logic [7:0]        BOOST_GAIN_RST       = 8'd15;
    localparam logic [7:0]        BOOST_LIMIT_RST      = 8'd120;
    localparam logic signed [5:0] RECENTER_COUNT_RST   = 6'sd20;

    // Curve count limits: pre-update clamp and final saturation
    localparam logic signed [3:0] COUNT_LIMIT = 4'sd5;
    localparam logic signed [4:0] COUNT_SAT   = 5'sd7;

    // Queue depth between the two halves and on the result side
    localparam int QUEUE_DEPTH_DEF = 2;

    // Direction codes
    localparam logic signed [3:0] DIR_STRAIGHT  = 4'sd0;
    localparam logic signed [3:0] DIR_POS1      = 4'sd1;
    localparam logic signed [3:0] DIR_POS2      = 4'sd2;
    localparam logic signed [3:0] DIR_PIVOT_POS = 4'sd3;
    localparam logic signed [3:0] DIR_NEG1      = -4'sd1;
    localparam logic signed [3:0] DIR_NEG2      = -4'sd2;
    localparam logic signed [3:0] DIR_PIVOT_NEG = -4'sd3;
    localparam logic signed [3:0] DIR_STOP      = 4'sd5;

    // /10 by reciprocal: exact floor for values below 16384
    localparam logic [11:0] RECIP_10   = 12'd3277;
    localparam int          RECIP_SHIFT = 15;

    // Sensor decode result, carried from front to back
    typedef enum logic [3:0] {
        ACT_HOLD       = 4'd0,
        ACT_STOP       = 4'd1,
        ACT_CENTRE     = 4'd2,
        ACT_PIVOT_POS  = 4'd3,
        ACT_PIVOT_NEG  = 4'd4,
        ACT_CURVE_POS1 = 4'd5,
        ACT_CURVE_NEG1 = 4'd6,
        ACT_CURVE_POS2 = 4'd7,
        ACT_CURVE_NEG2 = 4'd8
    } lfsc_action_t;

    typedef struct packed {
        logic sensor_1;
        logic sensor_2;
        logic sensor_3;
        logic sensor_4;
        logic sensor_5;
    } lfsc_sample_t;

    typedef struct packed {
        logic [7:0]        motor_a_pwm;
        logic              motor_a_in1;
        logic              motor_a_in2;
        logic [7:0]        motor_b_pwm;
        logic              motor_b_in1;
        logic              motor_b_in2;
        logic signed [3:0] curve_direction_now;
        logic signed [3:0] curve_count_now;
    } lfsc_result_t;

    typedef struct packed {
        logic [7:0]        base_speed;
        logic [7:0]        pivot_speed;
        logic [7:0]        inner_turn_speed;
        logic [7:0]        boost_gain;
        logic [7:0]        boost_limit;
        logic signed [5:0] recenter_count;
    } lfsc_cfg_t;

endpackage

### hw/rtl/lfsc_fifo.sv
// Small register queue, first in first out, generic width and depth.
// Depends on nothing but its parameters.

module lfsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_wr, do_rd;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/lfsc_front.sv
// Front end: takes sensor samples and decodes each into a steering action.
// Depends on lfsc_pkg.

module lfsc_front import lfsc_pkg::*; (
    input  logic         push,
    input  lfsc_sample_t sample,
    input  logic         cmd_full,
    output logic         cmd_push,
    output lfsc_action_t cmd_action
);

    logic s1, s2, s3, s4, s5;

    assign s1 = sample.sensor_1;
    assign s2 = sample.sensor_2;
    assign s3 = sample.sensor_3;
    assign s4 = sample.sensor_4;
    assign s5 = sample.sensor_5;

    assign cmd_push = push && !cmd_full;

    // priority decode, first match wins
    always_comb
    begin
        priority if (s1 && s2 && s3 && s4 && s5)
            cmd_action = ACT_STOP;
        else if (s3 && !s1 && !s2 && !s4 && !s5)
            cmd_action = ACT_CENTRE;
        else if (s5 && s4)
            cmd_action = ACT_PIVOT_POS;
        else if (s1 && s2)
            cmd_action = ACT_PIVOT_NEG;
        else if (s2 && !s4)
            cmd_action = ACT_CURVE_POS1;
        else if (s4 && !s2)
            cmd_action = ACT_CURVE_NEG1;
        else if (s1)
            cmd_action = ACT_CURVE_POS2;
        else if (s5)
            cmd_action = ACT_CURVE_NEG2;
        else
            cmd_action = ACT_HOLD;
    end

endmodule

### hw/rtl/lfsc_back.sv
// Back end: holds curve count, direction and smoothed speed, drives the motors from the
// old state and applies each decoded action. Depends on lfsc_pkg.

module lfsc_back import lfsc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  lfsc_cfg_t    cfg,
    input  logic         cmd_empty,
    input  lfsc_action_t cmd_action,
    output logic         cmd_pop,
    input  logic         res_full,
    output logic         res_push,
    output lfsc_result_t res_data
);

    logic signed [3:0]  count_reg, count_next;
    logic signed [3:0]  dir_reg, dir_next;
    logic [7:0]         prev_speed_reg, prev_speed_next;

    logic               fire;
    logic signed [12:0] count_ext, gain_ext, prod, neg_prod, limit_ext;
    logic [7:0]         lboost, rboost;
    logic [11:0]        mix;
    logic [23:0]        mix_scaled;
    logic [7:0]         quot, smoothed;
    logic               slow_zone;
    logic [8:0]         a_sum, b_sum;
    logic [7:0]         a_pwm, b_pwm;
    logic               a1, a2, b1, b2;
    logic signed [3:0]  count_clamped;
    logic signed [4:0]  count_upd, count_sat;
    logic signed [2:0]  delta;

    assign fire     = !cmd_empty && !res_full;
    assign cmd_pop  = fire;
    assign res_push = fire;

    // boost from the stored (unclamped) count
    assign count_ext = {{9{count_reg[3]}}, count_reg};
    assign gain_ext  = $signed({5'b0, cfg.boost_gain});
    assign limit_ext = $signed({5'b0, cfg.boost_limit});
    assign prod      = count_ext * gain_ext;
    assign neg_prod  = -prod;

    always_comb
    begin
        if (prod <= 13'sd0)
            lboost = '0;
        else if (prod > limit_ext)
            lboost = cfg.boost_limit;
        else
            lboost = prod[7:0];

        if (neg_prod <= 13'sd0)
            rboost = '0;
        else if (neg_prod > limit_ext)
            rboost = cfg.boost_limit;
        else
            rboost = neg_prod[7:0];
    end

    // (7*prev + 3*base) / 10
    assign mix        = ({4'b0, prev_speed_reg} << 3) - {4'b0, prev_speed_reg}
                      + ({4'b0, cfg.base_speed} << 1) + {4'b0, cfg.base_speed};
    assign mix_scaled = {12'b0, mix} * {12'b0, RECIP_10};
    assign quot       = mix_scaled[RECIP_SHIFT+7:RECIP_SHIFT];

    assign slow_zone       = (dir_reg == DIR_NEG1) || (dir_reg == DIR_STRAIGHT)
                          || (dir_reg == DIR_POS1);
    assign smoothed        = slow_zone ? quot : cfg.base_speed;
    assign prev_speed_next = (fire && slow_zone) ? quot : prev_speed_reg;

    assign a_sum = {1'b0, smoothed} + {1'b0, lboost};
    assign b_sum = {1'b0, smoothed} + {1'b0, rboost};

    always_comb
    begin
        a1    = 1'b0;
        a2    = 1'b1;
        b1    = 1'b1;
        b2    = 1'b0;
        a_pwm = '0;
        b_pwm = '0;
        unique case (dir_reg)
            DIR_STRAIGHT:
            begin
                a_pwm = cfg.base_speed;
                b_pwm = cfg.base_speed;
            end
            DIR_NEG1, DIR_NEG2:
            begin
                b_pwm = cfg.inner_turn_speed;
                a_pwm = a_sum[8] ? 8'hFF : a_sum[7:0];
            end
            DIR_POS1, DIR_POS2:
            begin
                b_pwm = b_sum[8] ? 8'hFF : b_sum[7:0];
                a_pwm = cfg.inner_turn_speed;
            end
            DIR_PIVOT_NEG:
            begin
                a1    = 1'b1;
                a2    = 1'b0;
                b_pwm = cfg.pivot_speed;
            end
            DIR_PIVOT_POS:
            begin
                b1    = 1'b0;
                b2    = 1'b1;
                a_pwm = cfg.pivot_speed;
            end
            default:
            begin
                a_pwm = '0;
                b_pwm = '0;
            end
        endcase
    end

    // state update
    always_comb
    begin
        if (count_reg > COUNT_LIMIT)
            count_clamped = COUNT_LIMIT;
        else if (count_reg < -COUNT_LIMIT)
            count_clamped = -COUNT_LIMIT;
        else
            count_clamped = count_reg;

        delta    = 3'sd0;
        dir_next = dir_reg;
        unique case (cmd_action)
            ACT_STOP:
                dir_next = DIR_STOP;
            ACT_CENTRE:
            begin
                if ({{2{count_clamped[3]}}, count_clamped} == cfg.recenter_count)
                    dir_next = DIR_STRAIGHT;
            end
            ACT_PIVOT_POS:
            begin
                dir_next = DIR_PIVOT_POS;
                delta    = 3'sd1;
            end
            ACT_PIVOT_NEG:
            begin
                dir_next = DIR_PIVOT_NEG;
                delta    = -3'sd1;
            end
            ACT_CURVE_POS1:
            begin
                dir_next = DIR_POS1;
                delta    = 3'sd1;
            end
            ACT_CURVE_NEG1:
            begin
                dir_next = DIR_NEG1;
                delta    = -3'sd1;
            end
            ACT_CURVE_POS2:
            begin
                dir_next = DIR_POS2;
                delta    = 3'sd2;
            end
            ACT_CURVE_NEG2:
            begin
                dir_next = DIR_NEG2;
                delta    = -3'sd2;
            end
            default:
                dir_next = dir_reg;
        endcase

        count_upd = {count_clamped[3], count_clamped} + {{2{delta[2]}}, delta};
        if (count_upd > COUNT_SAT)
            count_sat = COUNT_SAT;
        else if (count_upd < -COUNT_SAT)
            count_sat = -COUNT_SAT;
        else
            count_sat = count_upd;
        count_next = count_sat[3:0];
    end

    always_comb
    begin
        res_data.motor_a_pwm         = a_pwm;
        res_data.motor_a_in1         = a1;
        res_data.motor_a_in2         = a2;
        res_data.motor_b_pwm         = b_pwm;
        res_data.motor_b_in1         = b1;
        res_data.motor_b_in2         = b2;
        res_data.curve_direction_now = dir_next;
        res_data.curve_count_now     = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            dir_reg        <= DIR_STRAIGHT;
            prev_speed_reg <= BASE_SPEED_RST;
        end
        else if (fire)
        begin
            count_reg      <= count_next;
            dir_reg        <= dir_next;
            prev_speed_reg <= prev_speed_next;
        end
    end

endmodule

### hw/rtl/line_follower_steering_controller.sv
// Line follower steering controller: top level with configuration registers and APB port.
// Depends on lfsc_pkg, lfsc_front, lfsc_back and lfsc_fifo.
//
// One five-bit sensor sample in, one motor command out, at a sustained rate of one
// sample per clock cycle when neither queue stalls. The front end decodes each sample
// into a steering action and queues it; the back end applies actions one per cycle
// while an action is queued and the result queue has room, its count, direction and
// smoothed-speed registers feeding each update into the next, and places each result
// in the result queue. Both queues hold QUEUE_DEPTH entries, so either side may stall
// on its own. Registers sit at byte addresses 0, 4, ... 20 and may be rewritten only
// while no transaction is in flight.

module line_follower_steering_controller import lfsc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // sample side
    input  logic              push,
    output logic              full,
    input  lfsc_sample_t      sample,
    // result side
    input  logic              pop,
    output logic              empty,
    output lfsc_result_t      result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    lfsc_cfg_t    cfg_reg;
    lfsc_reg_t    reg_sel;
    logic         cfg_wr;

    logic         cmd_push, cmd_full, cmd_empty, cmd_pop;
    lfsc_action_t cmd_action_in, cmd_action_out;
    logic [$bits(lfsc_action_t)-1:0] cmd_raw;

    logic         res_push, res_full;
    lfsc_result_t res_data;
    logic [$bits(lfsc_result_t)-1:0] res_raw;

    assign pready  = 1'b1;
    assign reg_sel = lfsc_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed       <= BASE_SPEED_RST;
            cfg_reg.pivot_speed      <= PIVOT_SPEED_RST;
            cfg_reg.inner_turn_speed <= INNER_TURN_SPEED_RST;
            cfg_reg.boost_gain       <= BOOST_GAIN_RST;
            cfg_reg.boost_limit      <= BOOST_LIMIT_RST;
            cfg_reg.recenter_count   <= RECENTER_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_BASE_SPEED:       cfg_reg.base_speed       <= pwdata[7:0];
                REG_PIVOT_SPEED:      cfg_reg.pivot_speed      <= pwdata[7:0];
                REG_INNER_TURN_SPEED: cfg_reg.inner_turn_speed <= pwdata[7:0];
                REG_BOOST_GAIN:       cfg_reg.boost_gain       <= pwdata[7:0];
                REG_BOOST_LIMIT:      cfg_reg.boost_limit      <= pwdata[7:0];
                REG_RECENTER_COUNT:   cfg_reg.recenter_count   <= $signed(pwdata[5:0]);
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_BASE_SPEED:       prdata = {24'b0, cfg_reg.base_speed};
            REG_PIVOT_SPEED:      prdata = {24'b0, cfg_reg.pivot_speed};
            REG_INNER_TURN_SPEED: prdata = {24'b0, cfg_reg.inner_turn_speed};
            REG_BOOST_GAIN:       prdata = {24'b0, cfg_reg.boost_gain};
            REG_BOOST_LIMIT:      prdata = {24'b0, cfg_reg.boost_limit};
            REG_RECENTER_COUNT:   prdata = {{26{cfg_reg.recenter_count[5]}},
                                            cfg_reg.recenter_count};
            default:              prdata = '0;
        endcase
    end

    lfsc_front u_front (
        .push       (push),
        .sample     (sample),
        .cmd_full   (cmd_full),
        .cmd_push   (cmd_push),
        .cmd_action (cmd_action_in)
    );

    assign full = cmd_full;

    lfsc_fifo #(
        .WIDTH ($bits(lfsc_action_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_action_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_raw),
        .empty   (cmd_empty)
    );

    assign cmd_action_out = lfsc_action_t'(cmd_raw);

    lfsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_empty  (cmd_empty),
        .cmd_action (cmd_action_out),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    lfsc_fifo #(
        .WIDTH ($bits(lfsc_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_raw),
        .empty   (empty)
    );

    assign result = lfsc_result_t'(res_raw);

endmodule
